[design/sa32w_pkg.sv]
package sa32w_pkg;

  // Adler-32 modulus and widths
  localparam int unsigned SUM_W       = 16;
  localparam logic [SUM_W:0] ADLER_MOD = 17'd65521;

  localparam int unsigned CFG_W       = 12;
  localparam int unsigned MB_SHIFT    = 20;
  localparam int unsigned OFFSET_W    = 33;
  localparam int unsigned SIZE_W      = 25;
  localparam int unsigned CHECKSUM_W  = 32;

  // Chunk size saturates here
  localparam logic [SIZE_W-1:0] MAX_CHUNK_BYTES = 25'd16777216;

  // Reset value of the size limit register
  localparam logic [CFG_W-1:0] MAX_MB_RESET = 12'd1;

  // Action codes
  localparam logic ACT_DATA     = 1'b0;
  localparam logic ACT_FINALIZE = 1'b1;

  // Report kinds
  localparam logic REPORT_CHUNK = 1'b0;
  localparam logic REPORT_CLOSE = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       chunk_last;
  } in_word_t;

  typedef struct packed {
    logic                  report_kind;
    logic [OFFSET_W-1:0]   chunk_offset;
    logic [SIZE_W-1:0]     chunk_size;
    logic                  file_opened;
    logic                  file_closed;
    logic [CHECKSUM_W-1:0] file_checksum;
  } out_word_t;

  // Handshake from the pipeline registers into the core
  typedef struct packed {
    logic item_valid;
    logic out_free;
  } pipe_req_t;

  // Handshake from the core back to the pipeline registers
  typedef struct packed {
    logic consume;
    logic res_valid;
  } pipe_rsp_t;

endpackage

[design/sa32w_adler.sv]
module sa32w_adler (
  input  logic [sa32w_pkg::SUM_W-1:0] sum_low,
  input  logic [sa32w_pkg::SUM_W-1:0] sum_high,
  input  logic [7:0]                  data_byte,
  output logic [sa32w_pkg::SUM_W-1:0] sum_low_new,
  output logic [sa32w_pkg::SUM_W-1:0] sum_high_new
);
  import sa32w_pkg::*;

  logic [SUM_W:0] low_raw;
  logic [SUM_W:0] low_red;
  logic [SUM_W:0] high_raw;
  logic [SUM_W:0] high_red;

  // Low sum: add byte, one conditional subtract
  always_comb begin
    low_raw = {1'b0, sum_low} + {{(SUM_W-7){1'b0}}, data_byte};
    low_red = (low_raw >= ADLER_MOD) ? (low_raw - ADLER_MOD) : low_raw;
    sum_low_new = low_red[SUM_W-1:0];
  end

  // High sum: add the new low sum, one conditional subtract
  always_comb begin
    high_raw = {1'b0, sum_high} + {1'b0, sum_low_new};
    high_red = (high_raw >= ADLER_MOD) ? (high_raw - ADLER_MOD) : high_raw;
    sum_high_new = high_red[SUM_W-1:0];
  end

endmodule

[design/sa32w_core.sv]
module sa32w_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sa32w_pkg::CFG_W-1:0] max_mb,
  input  sa32w_pkg::pipe_req_t       req,
  input  sa32w_pkg::in_word_t        item,
  output sa32w_pkg::pipe_rsp_t       rsp,
  output sa32w_pkg::out_word_t       result
);
  import sa32w_pkg::*;

  // File and chunk state
  logic                open_r,     open_nxt;
  logic                opened_r,   opened_nxt;
  logic [OFFSET_W-1:0] fbytes_r,   fbytes_nxt;
  logic [SIZE_W-1:0]   ccount_r,   ccount_nxt;
  logic [SUM_W-1:0]    slow_r,     slow_nxt;
  logic [SUM_W-1:0]    shigh_r,    shigh_nxt;

  logic [SUM_W-1:0]    base_low;
  logic [SUM_W-1:0]    base_high;
  logic [SUM_W-1:0]    new_low;
  logic [SUM_W-1:0]    new_high;
  logic [OFFSET_W-1:0] base_bytes;
  logic                opened_base;
  logic [SIZE_W-1:0]   cnt_inc;
  logic [OFFSET_W:0]   bytes_sum;
  logic [OFFSET_W-1:0] bytes_sat;
  logic [OFFSET_W-1:0] limit;
  logic                closing;
  logic                is_final;
  logic                res_valid;
  logic                consume;

  // A data word with no file open starts a fresh file
  assign base_low    = open_r ? slow_r   : {{(SUM_W-1){1'b0}}, 1'b1};
  assign base_high   = open_r ? shigh_r  : '0;
  assign base_bytes  = open_r ? fbytes_r : '0;
  assign opened_base = open_r ? opened_r : 1'b1;

  sa32w_adler u_adler (
    .sum_low      (base_low),
    .sum_high     (base_high),
    .data_byte    (item.data_byte),
    .sum_low_new  (new_low),
    .sum_high_new (new_high)
  );

  // Chunk count saturates, file size saturates at all ones
  always_comb begin
    cnt_inc   = (ccount_r < MAX_CHUNK_BYTES) ? (ccount_r + 1'b1) : ccount_r;
    bytes_sum = {1'b0, base_bytes} + {{(OFFSET_W+1-SIZE_W){1'b0}}, cnt_inc};
    bytes_sat = bytes_sum[OFFSET_W] ? '1 : bytes_sum[OFFSET_W-1:0];
    limit     = {{(OFFSET_W-CFG_W-MB_SHIFT){1'b0}}, max_mb, {MB_SHIFT{1'b0}}};
    closing   = bytes_sat > limit;
  end

  // Handshake: words with no report never wait on the output
  assign is_final  = (item.action == ACT_FINALIZE);
  assign res_valid = is_final ? open_r : item.chunk_last;
  assign consume   = req.item_valid && (!res_valid || req.out_free);

  assign rsp.consume   = consume;
  assign rsp.res_valid = res_valid;

  // Report word
  always_comb begin
    if (is_final) begin
      result.report_kind   = REPORT_CLOSE;
      result.chunk_offset  = '0;
      result.chunk_size    = '0;
      result.file_opened   = 1'b0;
      result.file_closed   = 1'b1;
      result.file_checksum = {shigh_r, slow_r};
    end else begin
      result.report_kind   = REPORT_CHUNK;
      result.chunk_offset  = base_bytes;
      result.chunk_size    = cnt_inc;
      result.file_opened   = opened_base;
      result.file_closed   = closing;
      result.file_checksum = {new_high, new_low};
    end
  end

  // State update
  always_comb begin
    open_nxt   = open_r;
    opened_nxt = opened_r;
    fbytes_nxt = fbytes_r;
    ccount_nxt = ccount_r;
    slow_nxt   = slow_r;
    shigh_nxt  = shigh_r;
    if (consume) begin
      if (is_final) begin
        if (open_r) begin
          open_nxt   = 1'b0;
          opened_nxt = 1'b0;
          fbytes_nxt = '0;
          ccount_nxt = '0;
        end
      end else begin
        open_nxt  = 1'b1;
        slow_nxt  = new_low;
        shigh_nxt = new_high;
        if (item.chunk_last) begin
          opened_nxt = 1'b0;
          ccount_nxt = '0;
          open_nxt   = !closing;
          fbytes_nxt = closing ? '0 : bytes_sat;
        end else begin
          opened_nxt = opened_base;
          ccount_nxt = cnt_inc;
          fbytes_nxt = base_bytes;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      opened_r <= 1'b0;
      fbytes_r <= '0;
      ccount_r <= '0;
      slow_r   <= {{(SUM_W-1){1'b0}}, 1'b1};
      shigh_r  <= '0;
    end else begin
      open_r   <= open_nxt;
      opened_r <= opened_nxt;
      fbytes_r <= fbytes_nxt;
      ccount_r <= ccount_nxt;
      slow_r   <= slow_nxt;
      shigh_r  <= shigh_nxt;
    end
  end

endmodule

[design/segmented_adler32_writer_top.sv]
// Segmented Adler-32 writer.
// Input channel (in_valid / in_stall / in_data): one word per byte of a
// chunked stream, or a finalize word that closes the open file.
// Result channel (out_valid / out_stall / out_data): one report at each
// chunk end and at each finalize of an open file; other words give none.
// Configuration: cfg_wr_en writes cfg_wr_data into the file size limit in
// mebibytes; change it only while no words are in flight.
// Path: an accepted word is held in the input register, is processed into
// the output register, and its report is shown with out_valid from then on.
// Throughput: one word per cycle while no reporting word waits on a stalled
// report; the checksum update and the file size add and compare both finish
// between the input and output registers.
// Stall: while out_stall holds a report, the next reporting word waits in
// the input register and in_stall rises; words that give no report still
// pass. Reset (rst_n low, synchronous) empties both registers, closes any
// file and sets the limit to one mebibyte.
module segmented_adler32_writer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sa32w_pkg::in_word_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sa32w_pkg::out_word_t         out_data,
  input  logic                         cfg_wr_en,
  input  logic [sa32w_pkg::CFG_W-1:0]  cfg_wr_data
);
  import sa32w_pkg::*;

  logic [CFG_W-1:0] max_mb_r;
  logic             in_valid_r, in_valid_nxt;
  in_word_t         in_word_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r;
  pipe_req_t        req;
  pipe_rsp_t        rsp;
  out_word_t        result;
  logic             in_load;
  logic             out_load;

  // Size limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mb_r <= MAX_MB_RESET;
    end else if (cfg_wr_en) begin
      max_mb_r <= cfg_wr_data;
    end
  end

  assign req.item_valid = in_valid_r;
  assign req.out_free   = !out_valid_r || !out_stall;

  sa32w_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .max_mb (max_mb_r),
    .req    (req),
    .item   (in_word_r),
    .rsp    (rsp),
    .result (result)
  );

  // Input register
  assign in_stall     = in_valid_r && !rsp.consume;
  assign in_load      = in_valid && !in_stall;
  assign in_valid_nxt = in_load ? 1'b1 : (rsp.consume ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_word_r <= in_data;
    end
  end

  // Output register
  assign out_load      = rsp.consume && rsp.res_valid;
  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

[tb/adler_report_checker.sv]
module adler_report_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  sa32w_pkg::in_word_t           in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sa32w_pkg::out_word_t          out_data,
  input  logic                          cfg_wr_en,
  input  logic [sa32w_pkg::CFG_W-1:0]   cfg_wr_data,
  output int                            mismatches,
  output int                            reports_pending,
  output int                            reports_seen,
  output int                            closes_seen
);
  import sa32w_pkg::*;

  // Predicted writer state
  logic [CFG_W-1:0]    limit_mb;
  logic                file_open;
  logic                chunk_opened;
  logic [OFFSET_W-1:0] bytes_in_file;
  logic [SIZE_W-1:0]   chunk_len;
  logic [SUM_W-1:0]    s1;
  logic [SUM_W-1:0]    s2;

  // Reports predicted but not yet seen on the result channel, oldest first
  out_word_t reports_due[$];

  out_word_t due;
  logic      bad;

  // Advance the predicted writer by one accepted word
  task automatic advance_writer(input in_word_t w);
    out_word_t           rep;
    logic [SUM_W:0]      acc;
    logic [OFFSET_W:0]   grown;
    logic [OFFSET_W-1:0] limit_bytes;
    rep = '0;
    if (w.action == ACT_FINALIZE) begin
      // finalize with no file open is ignored
      if (file_open) begin
        rep.report_kind   = REPORT_CLOSE;
        rep.file_closed   = 1'b1;
        rep.file_checksum = {s2, s1};
        reports_due.push_back(rep);
        file_open     = 1'b0;
        bytes_in_file = '0;
        chunk_len     = '0;
        chunk_opened  = 1'b0;
      end
    end else begin
      if (!file_open) begin
        file_open     = 1'b1;
        chunk_opened  = 1'b1;
        bytes_in_file = '0;
        s1            = 16'd1;
        s2            = 16'd0;
      end
      // Adler-32 sums, one conditional subtract each
      acc = {1'b0, s1} + {{(SUM_W-7){1'b0}}, w.data_byte};
      if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
      s1  = acc[SUM_W-1:0];
      acc = {1'b0, s2} + {1'b0, s1};
      if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
      s2  = acc[SUM_W-1:0];
      if (chunk_len < MAX_CHUNK_BYTES) chunk_len = chunk_len + 1'b1;

      if (w.chunk_last) begin
        limit_bytes = '0;
        limit_bytes[CFG_W+MB_SHIFT-1:MB_SHIFT] = limit_mb;
        grown = {1'b0, bytes_in_file} + {{(OFFSET_W+1-SIZE_W){1'b0}}, chunk_len};
        rep.report_kind  = REPORT_CHUNK;
        rep.chunk_offset = bytes_in_file;
        rep.chunk_size   = chunk_len;
        rep.file_opened  = chunk_opened;
        // file size saturates at all ones
        if (grown[OFFSET_W]) bytes_in_file = '1;
        else bytes_in_file = grown[OFFSET_W-1:0];
        rep.file_closed   = bytes_in_file > limit_bytes;
        rep.file_checksum = {s2, s1};
        reports_due.push_back(rep);
        chunk_len    = '0;
        chunk_opened = 1'b0;
        if (rep.file_closed) begin
          file_open     = 1'b0;
          bytes_in_file = '0;
        end
      end
    end
  endtask

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      limit_mb      = MAX_MB_RESET;
      file_open     = 1'b0;
      chunk_opened  = 1'b0;
      bytes_in_file = '0;
      chunk_len     = '0;
      s1            = 16'd1;
      s2            = 16'd0;
      reports_due.delete();
      mismatches    = 0;
      reports_seen  = 0;
      closes_seen   = 0;
    end else begin
      if (cfg_wr_en) limit_mb = cfg_wr_data;
      if (in_valid && !in_stall) advance_writer(in_data);

      if (out_valid && !out_stall) begin
        reports_seen++;
        if (out_data.file_closed === 1'b1) closes_seen++;
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report with none due: %h", $time, out_data);
        end else begin
          due = reports_due.pop_front();
          bad = (out_data.report_kind   !== due.report_kind)  ||
                (out_data.chunk_offset  !== due.chunk_offset) ||
                (out_data.chunk_size    !== due.chunk_size)   ||
                (out_data.file_opened   !== due.file_opened)  ||
                (out_data.file_closed   !== due.file_closed)  ||
                (out_data.file_checksum !== due.file_checksum);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: report mismatch (expected/actual): kind %0d/%0d ",
                        "offset %0d/%0d size %0d/%0d opened %0d/%0d ",
                        "closed %0d/%0d checksum %h/%h"}, $time,
                       due.report_kind, out_data.report_kind,
                       due.chunk_offset, out_data.chunk_offset,
                       due.chunk_size, out_data.chunk_size,
                       due.file_opened, out_data.file_opened,
                       due.file_closed, out_data.file_closed,
                       due.file_checksum, out_data.file_checksum);
          end
        end
      end
    end
    reports_pending = reports_due.size();
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  import sa32w_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_word_t         in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_word_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  int mismatches;
  int reports_pending;
  int reports_seen;
  int closes_seen;
  int cycle_count = 0;
  int words_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;

  segmented_adler32_writer_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  adler_report_checker report_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatches      (mismatches),
    .reports_pending (reports_pending),
    .reports_seen    (reports_seen),
    .closes_seen     (closes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still due", cycle_count,
               reports_pending);
      $display("FAIL");
      $finish;
    end
  end

  // Result side back-pressure: calm stretches, short blips, the odd long hold
  initial begin : stall_gen
    int r;
    int n;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall <= 1'b0;
        n = $urandom_range(5, 60);
      end else if (r < 93) begin
        out_stall <= 1'($urandom_range(0, 1));
        n = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(10, 80);
      end
      repeat (n) @(negedge clk);
    end
  end

  // Offer one word after an optional gap; returns at the falling edge after it is taken
  task automatic send_word(input in_word_t w);
    int r;
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) burst_left = $urandom_range(20, 60);
        else if (r < 60) gap = 0;
        else if (r < 94) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_data(input logic [7:0] b, input logic last);
    in_word_t w;
    w.action     = ACT_DATA;
    w.data_byte  = b;
    w.chunk_last = last;
    send_word(w);
  endtask

  // byte and last bits are don't-care on finalize, so keep them random
  task automatic send_finalize();
    in_word_t w;
    w.action     = ACT_FINALIZE;
    w.data_byte  = 8'($urandom);
    w.chunk_last = 1'($urandom);
    send_word(w);
  endtask

  // ends = 0 leaves the chunk open (no last marker)
  task automatic send_chunk(input int len, input bit all_ones, input bit ends);
    for (int i = 0; i < len; i++)
      send_data(all_ones ? 8'hFF : 8'($urandom), ends && (i == len - 1));
  endtask

  // Register write once nothing is in flight
  task automatic write_limit(input logic [CFG_W-1:0] mb);
    in_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mb;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed chunks; some aborted by finalize, some stray finalizes
  task automatic random_phase(input int quota);
    int start;
    int len;
    int r;
    bit ones;
    start = words_sent;
    while (words_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 8);
      else if (r < 93) len = $urandom_range(9, 40);
      else len = $urandom_range(200, 320);
      ones = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_chunk(len, ones, 1'b0);
        send_finalize();
      end else begin
        send_chunk(len, ones, 1'b1);
        if (r < 14) send_finalize();
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: finalize edge cases, byte extremes, immediate close at limit 0
    send_finalize();
    send_data(8'h00, 1'b1);
    send_data(8'hFF, 1'b0);
    send_data(8'h80, 1'b0);
    send_data(8'h7F, 1'b1);
    send_data(8'h01, 1'b0);
    send_finalize();
    send_finalize();
    send_data(8'hFF, 1'b1);
    write_limit(12'd0);
    send_data(8'hAA, 1'b0);
    send_data(8'h55, 1'b1);
    send_finalize();
    send_data(8'hFF, 1'b1);

    // random traffic across several limits
    write_limit(12'd4095);
    random_phase(300);
    write_limit(12'd0);
    random_phase(250);
    write_limit(12'($urandom_range(1, 4094)));
    random_phase(300);
    write_limit(12'd1);
    random_phase(300);
    write_limit(12'($urandom));
    random_phase(250);

    // drain
    in_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);

    $display("sent %0d words; checked %0d reports, %0d closing a file",
             words_sent, reports_seen, closes_seen);
    $display("limits 0, 1, 4095 and random; finalize with no file, mid-chunk and after chunks");
    if (mismatches == 0 && reports_pending == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", mismatches, reports_pending);
      $display("FAIL");
    end
    $finish;
  end

endmodule
